// ===== design/edp_pkg.sv =====
// shared constants and types for the edit distance engine
package edp_pkg;

   localparam int MAX_LEN_DEF = 64;
   localparam int MODE_W      = 2;
   localparam int SYM_W       = 8;
   localparam int DIST_W      = 7;

   localparam logic [MODE_W-1:0] MODE_FIRST   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SECOND  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

   // sequencer commands to the cost row unit
   typedef struct packed {
      logic init_wr;
      logic issue;
      logic row_start;
   } cost_ctl_type;

endpackage

// ===== design/edp_text_store.sv =====
// two byte stores with fill counts and the sticky drop flag
module edp_text_store #(
   parameter int MAX_LEN = edp_pkg::MAX_LEN_DEF,
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
   localparam int CW = $clog2(MAX_LEN + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    app_en,
   input  logic                    app_second,
   input  logic [edp_pkg::SYM_W-1:0] app_sym,
   input  logic                    clear,
   input  logic                    rd_first_en,
   input  logic [AW-1:0]           rd_first_addr,
   input  logic                    rd_second_en,
   input  logic [AW-1:0]           rd_second_addr,
   output logic [edp_pkg::SYM_W-1:0] first_q,
   output logic [edp_pkg::SYM_W-1:0] second_q,
   output logic [CW-1:0]           first_count,
   output logic [CW-1:0]           second_count,
   output logic                    dropped
);

   logic [edp_pkg::SYM_W-1:0] first_mem_ff  [MAX_LEN];
   logic [edp_pkg::SYM_W-1:0] second_mem_ff [MAX_LEN];
   logic [edp_pkg::SYM_W-1:0] first_q_ff, second_q_ff;
   logic [CW-1:0]             first_count_ff, first_count_in;
   logic [CW-1:0]             second_count_ff, second_count_in;
   logic                      dropped_ff, dropped_in;
   logic                      first_room, second_room;
   logic                      first_we, second_we;

   assign first_room  = first_count_ff < CW'(MAX_LEN);
   assign second_room = second_count_ff < CW'(MAX_LEN);
   assign first_we    = app_en && !app_second && first_room;
   assign second_we   = app_en && app_second && second_room;

   always_ff @(posedge clock) begin
      if (first_we) begin
         first_mem_ff[first_count_ff[AW-1:0]] <= app_sym;
      end
      if (rd_first_en) begin
         first_q_ff <= first_mem_ff[rd_first_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (second_we) begin
         second_mem_ff[second_count_ff[AW-1:0]] <= app_sym;
      end
      if (rd_second_en) begin
         second_q_ff <= second_mem_ff[rd_second_addr];
      end
   end

   always_comb begin
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      dropped_in      = dropped_ff;
      if (clear) begin
         first_count_in  = '0;
         second_count_in = '0;
         dropped_in      = 1'b0;
      end else if (app_en) begin
         if (first_we) begin
            first_count_in = first_count_ff + CW'(1);
         end else if (second_we) begin
            second_count_in = second_count_ff + CW'(1);
         end else begin
            // string already full, byte is lost
            dropped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         dropped_ff      <= 1'b0;
      end else begin
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         dropped_ff      <= dropped_in;
      end
   end

   assign first_q      = first_q_ff;
   assign second_q     = second_q_ff;
   assign first_count  = first_count_ff;
   assign second_count = second_count_ff;
   assign dropped      = dropped_ff;

endmodule

// ===== design/edp_cost_row.sv =====
// cost row memory with the read-modify-write cell update
module edp_cost_row #(
   parameter int MAX_LEN = edp_pkg::MAX_LEN_DEF,
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
   localparam int CW = $clog2(MAX_LEN + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  edp_pkg::cost_ctl_type     ctl,
   input  logic [AW-1:0]             init_addr,
   input  logic [CW-1:0]             init_data,
   input  logic [AW-1:0]             rd_addr,
   input  logic [CW-1:0]             row_diag,
   input  logic [CW-1:0]             row_left,
   input  logic [edp_pkg::SYM_W-1:0] sym_a,
   input  logic [edp_pkg::SYM_W-1:0] sym_b,
   output logic [CW-1:0]             cell_value
);

   // entry k holds column k+1; column zero lives in row_left/row_diag
   logic [CW-1:0] cost_mem_ff [MAX_LEN];
   logic [CW-1:0] up_ff;
   logic          cmp_valid_ff;
   logic [AW-1:0] cmp_addr_ff;
   logic [CW-1:0] diag_ff, diag_in;
   logic [CW-1:0] left_ff, left_in;
   logic [CW-1:0] last_ff;
   logic [CW-1:0] min_ul, min_all, val;

   always_comb begin
      min_ul  = (up_ff < left_ff) ? up_ff : left_ff;
      min_all = (min_ul < diag_ff) ? min_ul : diag_ff;
      val     = (sym_a == sym_b) ? diag_ff : min_all + CW'(1);
   end

   always_ff @(posedge clock) begin
      priority if (ctl.init_wr) begin
         cost_mem_ff[init_addr] <= init_data;
      end else if (cmp_valid_ff) begin
         cost_mem_ff[cmp_addr_ff] <= val;
      end
      if (ctl.issue) begin
         up_ff <= cost_mem_ff[rd_addr];
      end
   end

   always_comb begin
      diag_in = diag_ff;
      left_in = left_ff;
      priority if (ctl.row_start) begin
         diag_in = row_diag;
         left_in = row_left;
      end else if (cmp_valid_ff) begin
         diag_in = up_ff;
         left_in = val;
      end
   end

   always_ff @(posedge clock) begin
      diag_ff <= diag_in;
      left_ff <= left_in;
      if (ctl.issue) begin
         cmp_addr_ff <= rd_addr;
      end
      if (cmp_valid_ff) begin
         last_ff <= val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= ctl.issue;
      end
   end

   assign cell_value = last_ff;

endmodule

// ===== design/edit_distance_engine.sv =====
// edit distance engine: sweep sequencer, text stores and cost row
// Usage: req_ channel carries items (req_mode, req_symbol); mode first/second
// appends req_symbol to that string, compute returns one result on the rsp_
// channel (rsp_distance, rsp_overflow) and clears both strings and the flag.
// Append transfers are accepted back to back while req_ready is high.
// A compute with an empty string skips the table sweep; otherwise it
// sweeps all n1*n2 cells (n1, n2 the string lengths), paced by
// the cost row memory, which takes one read and one write per cell.
// req_ready is low from a compute until its result enters the output register.
// The result sits in an output register; while the receiver stalls, appends
// are still taken, and a following compute holds its result until the
// register frees up.
// Bytes beyond MAX_LEN per string are dropped and reported in rsp_overflow.
// Reset clears the counts, the flag and the control state; the stores need
// no clearing pass, since only written entries are ever read.
module edit_distance_engine #(
   parameter int MAX_LEN = edp_pkg::MAX_LEN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [edp_pkg::MODE_W-1:0] req_mode,
   input  logic [edp_pkg::SYM_W-1:0]  req_symbol,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [edp_pkg::DIST_W-1:0] rsp_distance,
   output logic                       rsp_overflow
);

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW = $clog2(MAX_LEN + 1);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_INIT     = 3'd1;
   localparam logic [2:0] ST_ROWSTART = 3'd2;
   localparam logic [2:0] ST_ROW      = 3'd3;
   localparam logic [2:0] ST_DRAIN    = 3'd4;
   localparam logic [2:0] ST_COLLECT  = 3'd5;
   localparam logic [2:0] ST_FINISH   = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] n1_ff, n1_in;
   logic [CW-1:0] n2_ff, n2_in;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] res_ff, res_in;
   logic          ovf_ff, ovf_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [edp_pkg::DIST_W-1:0] rsp_distance_ff;
   logic          rsp_overflow_ff;

   logic          accept, app_en, clear, load_rsp;
   logic          rd_first_en, rd_second_en;
   logic [CW-1:0] row_m1, col_m1;
   logic [CW-1:0] first_count, second_count, cell_value;
   logic          dropped;
   logic [edp_pkg::SYM_W-1:0] first_q, second_q;
   edp_pkg::cost_ctl_type     ctl;

   assign row_m1    = row_ff - CW'(1);
   assign col_m1    = col_ff - CW'(1);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign app_en    = accept && ((req_mode == edp_pkg::MODE_FIRST) ||
                                 (req_mode == edp_pkg::MODE_SECOND));
   assign clear     = accept && (req_mode == edp_pkg::MODE_COMPUTE);
   assign load_rsp  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in      = state_ff;
      n1_in         = n1_ff;
      n2_in         = n2_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      res_in        = res_ff;
      ovf_in        = ovf_ff;
      rd_first_en   = 1'b0;
      rd_second_en  = 1'b0;
      ctl           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (clear) begin
               n1_in  = first_count;
               n2_in  = second_count;
               ovf_in = dropped;
               if ((first_count == '0) || (second_count == '0)) begin
                  // one string empty: distance is the other length
                  res_in   = (first_count == '0) ? second_count : first_count;
                  state_in = ST_FINISH;
               end else begin
                  col_in   = CW'(1);
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            ctl.init_wr = 1'b1;
            if (col_ff == n2_ff) begin
               row_in   = CW'(1);
               state_in = ST_ROWSTART;
            end else begin
               col_in = col_ff + CW'(1);
            end
         end
         ST_ROWSTART: begin
            rd_first_en   = 1'b1;
            ctl.row_start = 1'b1;
            col_in        = CW'(1);
            state_in      = ST_ROW;
         end
         ST_ROW: begin
            ctl.issue    = 1'b1;
            rd_second_en = 1'b1;
            if (col_ff == n2_ff) begin
               if (row_ff == n1_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  row_in   = row_ff + CW'(1);
                  state_in = ST_ROWSTART;
               end
            end else begin
               col_in = col_ff + CW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_COLLECT;
         end
         ST_COLLECT: begin
            res_in   = cell_value;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n1_ff  <= n1_in;
      n2_ff  <= n2_in;
      row_ff <= row_in;
      col_ff <= col_in;
      res_ff <= res_in;
      ovf_ff <= ovf_in;
      if (load_rsp) begin
         rsp_distance_ff <= edp_pkg::DIST_W'(res_ff);
         rsp_overflow_ff <= ovf_ff;
      end
   end

   edp_text_store #(
      .MAX_LEN (MAX_LEN)
   ) u_text (
      .clock          (clock),
      .reset          (reset),
      .app_en         (app_en),
      .app_second     (req_mode == edp_pkg::MODE_SECOND),
      .app_sym        (req_symbol),
      .clear          (clear),
      .rd_first_en    (rd_first_en),
      .rd_first_addr  (row_m1[AW-1:0]),
      .rd_second_en   (rd_second_en),
      .rd_second_addr (col_m1[AW-1:0]),
      .first_q        (first_q),
      .second_q       (second_q),
      .first_count    (first_count),
      .second_count   (second_count),
      .dropped        (dropped)
   );

   edp_cost_row #(
      .MAX_LEN (MAX_LEN)
   ) u_cost (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .init_addr  (col_m1[AW-1:0]),
      .init_data  (col_ff),
      .rd_addr    (col_m1[AW-1:0]),
      .row_diag   (row_m1),
      .row_left   (row_ff),
      .sym_a      (first_q),
      .sym_b      (second_q),
      .cell_value (cell_value)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule
